// ----- hw/rtl/pending_event_match_table_macros.svh -----
// assertion macros for the pending event match table
`ifndef PENDING_EVENT_MATCH_TABLE_MACROS_SVH
`define PENDING_EVENT_MATCH_TABLE_MACROS_SVH

`ifndef SYNTH
`define PEMT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PEMT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PEMT_ASSERT(label, prop, msg)
`define PEMT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- hw/rtl/pemt_pkg.sv -----
// shared constants and types of the pending event match table
`default_nettype none

package pemt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_NO_MATCH  = 3'd4;

    localparam logic       KIND_REGISTER = 1'b0;
    localparam logic [1:0] CODE_INVALID  = 2'd3;

    typedef struct packed {
        logic [31:0] list_address;
        logic [1:0]  event_code;
        logic [31:0] queue_address;
        logic [31:0] message_word;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       store;
        logic       keep;
        logic       take;
        logic       finish;
        logic       emit;
        logic       emit_pend;
        logic       emit_last;
        logic [2:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic invalid;
        logic full;
        logic at_end;
        logic match;
        logic pend;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/pending_event_match_table.sv -----
// pending event match table: top level
//
// input channel i_valid / o_ready carries one request: a register request
// (kind 0) stores list address, event type, queue and message unless the type
// is invalid or the table is full; a dispatch request (kind 1) removes every
// stored entry with the same list address and type, oldest first; the rest keep their order
// output channel o_valid / i_ready carries the results; o_last marks the
// final result of a request
// a register request answers with one result
// a dispatch walks the table one entry per cycle, but for holds while the
// output register is busy, through a single read port of the entry memory
// one request is worked on at a time; o_ready is high only while idle
// reset empties the table and drops any pending result
// when the receiver stalls, the result waits in the output register and
// the scan holds at the next match until that register frees
`default_nettype none

module pending_event_match_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_list_address,
    input  wire logic [1:0]  i_event_code,
    input  wire logic [31:0] i_queue_address,
    input  wire logic [31:0] i_message_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_out_queue,
    output logic [31:0]      o_out_message,
    output logic             o_last
);
    import pemt_pkg::*;

`include "pending_event_match_table_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    pemt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pemt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_list_address  (i_list_address),
        .i_event_code    (i_event_code),
        .i_queue_address (i_queue_address),
        .i_message_word  (i_message_word),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_queue     (o_out_queue),
        .o_out_message   (o_out_message),
        .o_last          (o_last)
    );

    `PEMT_ASSERT(a_emit_into_free_slot, cmd.emit |-> stat.out_free, "result overwrites a waiting one")
    `PEMT_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready, "request taken while busy")
    `PEMT_ASSERT(a_single_results_last, (o_valid && o_status != ST_DELIVERED) |-> o_last, "single result without last")
    `PEMT_ASSERT_ALWAYS(a_no_store_without_room, (cmd.store && i_rst_n) |-> !stat.full, "store into full table")

endmodule

`default_nettype wire

// ----- hw/rtl/pemt_datapath.sv -----
// table memory, scan pointers, pending result and output register
`default_nettype none

module pemt_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pemt_pkg::t_cmd i_cmd,
    output pemt_pkg::t_stat    o_stat,
    input  wire logic          i_kind,
    input  wire logic [31:0]   i_list_address,
    input  wire logic [1:0]    i_event_code,
    input  wire logic [31:0]   i_queue_address,
    input  wire logic [31:0]   i_message_word,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [31:0]        o_out_queue,
    output logic [31:0]        o_out_message,
    output logic               o_last
);
    import pemt_pkg::*;

    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    t_entry             r_req;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_e;
    logic [CNT_W-1:0]   r_wr;
    logic [RES_W-1:0]   r_n;
    logic [31:0]        r_pend_queue;
    logic [31:0]        r_pend_msg;
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [31:0]        r_out_queue;
    logic [31:0]        r_out_msg;
    logic               r_out_last;

    logic [CNT_W-1:0]   n_e;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               we;
    logic               advance;

    assign advance = i_cmd.keep | i_cmd.take;
    assign n_e     = r_e + 1'b1;

    always_comb begin
        priority if (i_cmd.load) begin
            rd_addr = '0;
        end else if (advance) begin
            rd_addr = n_e[IDX_W-1:0];
        end else begin
            rd_addr = r_e[IDX_W-1:0];
        end
    end

    assign we      = i_cmd.store | i_cmd.keep;
    assign wr_addr = i_cmd.store ? r_count[IDX_W-1:0] : r_wr[IDX_W-1:0];
    assign wr_data = i_cmd.store ? r_req : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // request, pending and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req.list_address    <= i_list_address;
            r_req.event_code      <= i_event_code;
            r_req.queue_address   <= i_queue_address;
            r_req.message_word    <= i_message_word;
        end
        if (i_cmd.take) begin
            r_pend_queue <= r_rd_data.queue_address;
            r_pend_msg   <= r_rd_data.message_word;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_queue  <= i_cmd.emit_pend ? r_pend_queue : '0;
            r_out_msg    <= i_cmd.emit_pend ? r_pend_msg : '0;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_e         <= '0;
            r_wr        <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_e  <= '0;
                r_wr <= '0;
                r_n  <= '0;
            end else begin
                if (advance) begin
                    r_e <= n_e;
                end
                if (i_cmd.keep) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (i_cmd.take) begin
                    r_n <= r_n + 1'b1;
                end
            end
            priority if (i_cmd.store) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.finish) begin
                r_count <= r_wr;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.kind     = i_kind;
        o_stat.invalid  = (r_req.event_code == CODE_INVALID);
        o_stat.full     = (r_count >= CNT_W'(TABLE_DEPTH));
        o_stat.at_end   = (r_e >= r_count);
        o_stat.match    = (r_rd_data.list_address == r_req.list_address)
                        && (r_rd_data.event_code == r_req.event_code)
                        && (r_n < RES_W'(MAX_RESULTS));
        o_stat.pend     = (r_n != '0);
        o_stat.out_free = !r_out_valid || i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_queue   = r_out_queue;
    assign o_out_message = r_out_msg;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/pemt_ctrl.sv -----
// sequencing of register and dispatch requests
`default_nettype none

module pemt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire pemt_pkg::t_stat i_stat,
    output pemt_pkg::t_cmd      o_cmd
);
    import pemt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                end
            end
            S_REG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    priority if (i_stat.invalid) begin
                        o_cmd.emit_status = ST_INVALID;
                    end else if (i_stat.full) begin
                        o_cmd.emit_status = ST_FULL;
                    end else begin
                        o_cmd.emit_status = ST_ACCEPTED;
                        o_cmd.store       = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                priority if (i_stat.at_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_pend   = i_stat.pend;
                        o_cmd.emit_status = i_stat.pend ? ST_DELIVERED : ST_NO_MATCH;
                        o_cmd.finish      = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.match) begin
                    // hold the previous match until the output slot frees
                    if (!i_stat.pend || i_stat.out_free) begin
                        o_cmd.take        = 1'b1;
                        o_cmd.emit        = i_stat.pend;
                        o_cmd.emit_pend   = 1'b1;
                        o_cmd.emit_status = ST_DELIVERED;
                    end
                end else begin
                    o_cmd.keep = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load) begin
            n_state = (i_stat.kind == KIND_REGISTER) ? S_REG : S_SCAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the pending event match table: random and directed requests against a scoreboard
`timescale 1ns / 1ps

module tb;
    import pemt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 102;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] queue;
        logic [31:0] message;
        logic        last;
    } t_result;

    class event_table_tracker;
        logic [31:0] ent_list [TABLE_DEPTH];
        logic [1:0]  ent_type [TABLE_DEPTH];
        logic [31:0] ent_queue [TABLE_DEPTH];
        logic [31:0] ent_message [TABLE_DEPTH];
        int          fill;
        t_result     due_results [$];
        int          errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void add_result(logic [2:0] status, logic [31:0] q, logic [31:0] m,
                                 logic last);
            t_result r;
            r.status = status;
            r.queue = q;
            r.message = m;
            r.last = last;
            due_results.push_back(r);
        endfunction

        function void note_request(logic kind, logic [31:0] addr, logic [1:0] code,
                                   logic [31:0] q, logic [31:0] m);
            int wr;
            int n;
            if (kind == KIND_REGISTER) begin
                if (code == CODE_INVALID) begin
                    add_result(ST_INVALID, 32'h0, 32'h0, 1'b1);
                end else if (fill >= TABLE_DEPTH) begin
                    add_result(ST_FULL, 32'h0, 32'h0, 1'b1);
                end else begin
                    ent_list[fill] = addr;
                    ent_type[fill] = code;
                    ent_queue[fill] = q;
                    ent_message[fill] = m;
                    fill++;
                    add_result(ST_ACCEPTED, 32'h0, 32'h0, 1'b1);
                end
            end else begin
                wr = 0;
                n = 0;
                for (int rd = 0; rd < fill; rd++) begin
                    if (n < MAX_RESULTS && ent_list[rd] == addr && ent_type[rd] == code) begin
                        add_result(ST_DELIVERED, ent_queue[rd], ent_message[rd], 1'b0);
                        n++;
                    end else begin
                        ent_list[wr] = ent_list[rd];
                        ent_type[wr] = ent_type[rd];
                        ent_queue[wr] = ent_queue[rd];
                        ent_message[wr] = ent_message[rd];
                        wr++;
                    end
                end
                fill = wr;
                if (n == 0)
                    add_result(ST_NO_MATCH, 32'h0, 32'h0, 1'b1);
                else
                    due_results[due_results.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [2:0] status, logic [31:0] q, logic [31:0] m, logic last);
            t_result r;
            if (due_results.size() == 0) begin
                report($sformatf("result status %0d with no request pending", status));
            end else begin
                r = due_results.pop_front();
                if (status !== r.status)
                    report($sformatf("status %0d, wanted %0d", status, r.status));
                if (q !== r.queue)
                    report($sformatf("queue %h, wanted %h", q, r.queue));
                if (m !== r.message)
                    report($sformatf("message %h, wanted %h", m, r.message));
                if (last !== r.last)
                    report($sformatf("last %b, wanted %b", last, r.last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [31:0] i_list_address = 32'h0;
    logic [1:0]  i_event_code = 2'd0;
    logic [31:0] i_queue_address = 32'h0;
    logic [31:0] i_message_word = 32'h0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_out_queue;
    logic [31:0] o_out_message;
    logic        o_last;

    event_table_tracker tracker;
    int          send_idle_pct = 16;
    int          recv_idle_pct = 64;
    int          stall_cycles = 0;
    logic [31:0] addr_pool [4];

    pending_event_match_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_list_address  (i_list_address),
        .i_event_code    (i_event_code),
        .i_queue_address (i_queue_address),
        .i_message_word  (i_message_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_out_queue     (o_out_queue),
        .o_out_message   (o_out_message),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_status, o_out_queue, o_out_message, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("tb: done, errors");
        $finish;
    end

    task automatic drive_request(input logic kind, input logic [31:0] addr,
                                 input logic [1:0] code, input logic [31:0] q,
                                 input logic [31:0] m);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_list_address <= addr;
        i_event_code <= code;
        i_queue_address <= q;
        i_message_word <= m;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        tracker.note_request(kind, addr, code, q, m);
    endtask

    task automatic random_request();
        logic        kind;
        logic [31:0] addr;
        logic [1:0]  code;
        int          reg_pct;
        reg_pct = (tracker.fill < 6) ? 75 : (tracker.fill > 12) ? 40 : 60;
        kind = ($urandom_range(99) < reg_pct) ? KIND_REGISTER : ~KIND_REGISTER;
        if ($urandom_range(99) < 10)
            addr = $urandom;
        else
            addr = addr_pool[$urandom_range(3)];
        if ($urandom_range(99) < 6)
            code = CODE_INVALID;
        else
            code = 2'($urandom_range(2));
        drive_request(kind, addr, code, $urandom, $urandom);
    endtask

    initial begin
        tracker = new();
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = $urandom;
        addr_pool[3] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // invalid type, then dispatch on an empty table
        drive_request(KIND_REGISTER, 32'h0, CODE_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive_request(~KIND_REGISTER, 32'h0, 2'd0, 32'h0, 32'h0);
        // fill the table with one list address and type
        for (int k = 0; k < TABLE_DEPTH; k++)
            drive_request(KIND_REGISTER, 32'hFFFF_FFFF, 2'd2,
                          (k % 2) ? 32'hFFFF_FFFF : 32'h0,
                          (k % 2) ? 32'h0 : 32'hFFFF_FFFF);
        drive_request(KIND_REGISTER, 32'h0, 2'd0, 32'h1234_5678, 32'h9ABC_DEF0);
        drive_request(KIND_REGISTER, 32'h0, CODE_INVALID, 32'h0, 32'h0);
        drive_request(~KIND_REGISTER, 32'hFFFF_FFFF, CODE_INVALID, 32'h0, 32'h0);
        // every entry matches: full burst of results
        drive_request(~KIND_REGISTER, 32'hFFFF_FFFF, 2'd2, 32'h0, 32'h0);
        drive_request(KIND_REGISTER, 32'h0, 2'd0, $urandom, $urandom);
        drive_request(KIND_REGISTER, 32'h0, 2'd1, $urandom, $urandom);
        drive_request(~KIND_REGISTER, 32'h0, 2'd1, $urandom, $urandom);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 16 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_request();
        end

        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
